// File: hw/rtl/sacl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sacl_pkg: shared types and constants of the LRU cache tag unit
// Request and result formats, configuration register indexes, tag store row
// layout and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package sacl_pkg;

  // Sizing
  localparam int MAX_INDEX_BITS = 10;
  localparam int MAX_WAYS       = 8;
  localparam int COUNTER_BITS   = 32;

  localparam int ADDR_W   = 64;
  localparam int TAG_W    = 64;
  localparam int OUT_CNT_W = 32;
  localparam int SET_W    = (MAX_INDEX_BITS > 0) ? MAX_INDEX_BITS : 1;
  localparam int NUM_SETS = 1 << MAX_INDEX_BITS;
  localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int RANK_W   = WAY_W;
  localparam int IDXB_W   = $clog2(MAX_INDEX_BITS + 1);

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;
  localparam logic [CFG_IDX_W-1:0] CFG_CACHE_SIZE_LOG2 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_SIZE_LOG2  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS_LOG2       = 2'd2;

  localparam logic [4:0] RST_CACHE_SIZE_LOG2 = 5'd15;
  localparam logic [3:0] RST_LINE_SIZE_LOG2  = 4'd5;
  localparam logic [1:0] RST_WAYS_LOG2       = 2'd1;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // One access request
  typedef struct packed {
    logic              operation;
    logic [ADDR_W-1:0] address;
  } in_req_t;

  // One access result
  typedef struct packed {
    logic                 hit;
    logic [OUT_CNT_W-1:0] access_count;
    logic [OUT_CNT_W-1:0] read_count;
    logic [OUT_CNT_W-1:0] read_miss_count;
    logic [OUT_CNT_W-1:0] write_count;
    logic [OUT_CNT_W-1:0] write_miss_count;
  } out_result_t;

  // One way of a set as held in the tag store
  typedef struct packed {
    logic              valid;
    logic [RANK_W-1:0] rank;
    logic [TAG_W-1:0]  tag;
  } way_entry_t;

  typedef way_entry_t [MAX_WAYS-1:0] set_row_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;   // latch request, split address
    logic lookup;    // read the set row
    logic update;    // compare, write back row, bump counters
    logic clr_step;  // write one cleared row
  } sacl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;  // clear pointer at last row
    logic cfg_hit;   // a known register is being written
  } sacl_status_t;

endpackage : sacl_pkg
`default_nettype wire

// File: hw/rtl/set_assoc_lru_cache_tags_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_tags_unit: set-associative tag store with true LRU
// Looks up each access request, allocates on miss and keeps access counters.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive in_req and raise start; the request is taken at a
//   rising edge with start high and busy low.
//   Result channel: out_result is valid for exactly one cycle while out_valid
//   is high; it is registered at the end of the update step.
//   There is no back pressure; the receiver must take every result as it
//   appears. A request can be taken while the previous one writes back;
//   the set row is read in the lookup step, then compared and written back.
//   Configuration: cfg_valid/cfg_ready write channel, always ready. Writing a
//   known register clears the counters and starts the clearing pass; writes
//   to other indexes are ignored.
//   Reset and clearing pass: after reset, and after each configuration write,
//   busy stays high while every set row is invalidated, one row per cycle.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_tags_unit
  import sacl_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire in_req_t               in_req,
  output logic                       out_valid,
  output out_result_t                out_result,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  sacl_cmd_t    cmd;
  sacl_status_t status;

  assign cfg_ready = 1'b1;

  // sequencer
  sacl_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  // tag store and counters
  sacl_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .in_req     (in_req),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_valid  (out_valid),
    .out_result (out_result)
  );

endmodule : set_assoc_lru_cache_tags_unit
`default_nettype wire

// File: hw/rtl/sacl_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sacl_ctrl: sequencer of the LRU cache tag unit
// Runs the clearing pass, then steps each request through lookup and update.
// ----------------------------------------------------------------------------
module sacl_ctrl
  import sacl_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  output logic              busy,
  input  wire sacl_status_t status,
  output sacl_cmd_t         cmd
);

  typedef enum logic [3:0] {
    ST_CLEAR  = 4'b0001,
    ST_IDLE   = 4'b0010,
    ST_LOOKUP = 4'b0100,
    ST_UPDATE = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  // a new request may enter while the previous one writes back
  assign busy   = (state_r == ST_CLEAR) || (state_r == ST_LOOKUP);
  assign accept = start && !busy;

  // next state
  always_comb begin
    state_nxt = state_r;
    if (status.cfg_hit) begin
      state_nxt = ST_CLEAR;
    end else begin
      unique case (state_r)
        ST_CLEAR:  if (status.clr_last) state_nxt = ST_IDLE;
        ST_IDLE:   if (start) state_nxt = ST_LOOKUP;
        ST_LOOKUP: state_nxt = ST_UPDATE;
        ST_UPDATE: state_nxt = start ? ST_LOOKUP : ST_IDLE;
        default:   state_nxt = ST_CLEAR;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // commands
  always_comb begin
    cmd.capture  = accept;
    cmd.lookup   = (state_r == ST_LOOKUP);
    cmd.update   = (state_r == ST_UPDATE);
    cmd.clr_step = (state_r == ST_CLEAR);
  end

endmodule : sacl_ctrl
`default_nettype wire

// File: hw/rtl/sacl_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sacl_dpath: datapath of the LRU cache tag unit
// Configuration registers, address split, set-row tag store, tag compare,
// LRU rank update, saturating counters and the result register.
// ----------------------------------------------------------------------------
module sacl_dpath
  import sacl_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire sacl_cmd_t             cmd,
  output sacl_status_t               status,
  input  wire in_req_t               in_req,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output logic                       out_valid,
  output out_result_t                out_result
);

  // configuration registers
  logic [4:0] cache_log2_r;
  logic [3:0] line_log2_r;
  logic [1:0] ways_log2_r;
  logic       cfg_hit;

  assign cfg_hit = cfg_we && ((cfg_index == CFG_CACHE_SIZE_LOG2) ||
                              (cfg_index == CFG_LINE_SIZE_LOG2) ||
                              (cfg_index == CFG_WAYS_LOG2));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cache_log2_r <= RST_CACHE_SIZE_LOG2;
      line_log2_r  <= RST_LINE_SIZE_LOG2;
      ways_log2_r  <= RST_WAYS_LOG2;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CACHE_SIZE_LOG2: cache_log2_r <= cfg_data[4:0];
        CFG_LINE_SIZE_LOG2:  line_log2_r  <= cfg_data[3:0];
        CFG_WAYS_LOG2:       ways_log2_r  <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // geometry derived from configuration
  logic [5:0]          used_bits;
  logic [5:0]          idx_diff;
  logic [IDXB_W-1:0]   idx_bits;
  logic [4:0]          way_cnt;
  logic [MAX_WAYS-1:0] active;

  always_comb begin
    used_bits = 6'(ways_log2_r) + 6'(line_log2_r);
    idx_diff  = (6'(cache_log2_r) > used_bits) ? (6'(cache_log2_r) - used_bits) : 6'd0;
    if (idx_diff > 6'(MAX_INDEX_BITS)) begin
      idx_bits = IDXB_W'(MAX_INDEX_BITS);
    end else begin
      idx_bits = IDXB_W'(idx_diff);
    end
    way_cnt = 5'd1 << ways_log2_r;
    if (way_cnt > 5'(MAX_WAYS)) way_cnt = 5'(MAX_WAYS);
    for (int w = 0; w < MAX_WAYS; w++) begin
      active[w] = (5'(w) < way_cnt);
    end
  end

  // request capture: set index and tag
  logic [ADDR_W-1:0] shifted;
  logic [SET_W-1:0]  idx_mask;
  logic [5:0]        tag_shift;
  logic              op_r;
  logic [SET_W-1:0]  set_r;
  logic [TAG_W-1:0]  tag_r;

  always_comb begin
    shifted   = in_req.address >> line_log2_r;
    idx_mask  = ~({SET_W{1'b1}} << idx_bits);
    tag_shift = 6'(line_log2_r) + 6'(idx_bits);
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= in_req.operation;
      set_r <= shifted[SET_W-1:0] & idx_mask;
      tag_r <= in_req.address >> tag_shift;
    end
  end

  // clearing pointer
  logic [SET_W-1:0] clr_ptr_r;

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_hit) begin
      clr_ptr_r <= '0;
    end else if (cmd.clr_step) begin
      clr_ptr_r <= clr_ptr_r + SET_W'(1);
    end
  end

  always_comb begin
    status.clr_last = (clr_ptr_r == SET_W'(NUM_SETS - 1));
    status.cfg_hit  = cfg_hit;
  end

  // tag store: one row per set
  set_row_t         mem [NUM_SETS];
  set_row_t         rd_row_r;
  set_row_t         new_row;
  logic             mem_we;
  logic [SET_W-1:0] mem_wa;
  set_row_t         mem_wd;

  always_comb begin
    mem_we = cmd.clr_step || cmd.update;
    mem_wa = cmd.clr_step ? clr_ptr_r : set_r;
    mem_wd = cmd.clr_step ? set_row_t'('0) : new_row;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (cmd.lookup) rd_row_r <= mem[set_r];
  end

  // tag compare and victim choice
  logic [MAX_WAYS-1:0] match;
  logic [MAX_WAYS-1:0] invalid;
  logic                hit;
  logic                has_inv;
  logic [WAY_W-1:0]    found;
  logic [WAY_W-1:0]    inv_way;
  logic [WAY_W-1:0]    max_way;
  logic [RANK_W-1:0]   max_rank;
  logic [WAY_W-1:0]    victim;
  logic [RANK_W-1:0]   hit_rank;
  logic [RANK_W-1:0]   vic_rank;

  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      match[w]   = active[w] && rd_row_r[w].valid && (rd_row_r[w].tag == tag_r);
      invalid[w] = active[w] && !rd_row_r[w].valid;
    end
    hit     = |match;
    has_inv = |invalid;

    // lowest numbered match and invalid way
    found   = '0;
    inv_way = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (match[w])   found   = WAY_W'(w);
      if (invalid[w]) inv_way = WAY_W'(w);
    end

    // least recently used way, first on ties
    max_way  = '0;
    max_rank = rd_row_r[0].rank;
    for (int w = 1; w < MAX_WAYS; w++) begin
      if (active[w] && (rd_row_r[w].rank > max_rank)) begin
        max_way  = WAY_W'(w);
        max_rank = rd_row_r[w].rank;
      end
    end

    victim   = has_inv ? inv_way : max_way;
    hit_rank = rd_row_r[found].rank;
    vic_rank = max_rank;
  end

  // rank update and allocation
  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      new_row[w] = rd_row_r[w];
      if (hit) begin
        if (active[w] && rd_row_r[w].valid && (rd_row_r[w].rank < hit_rank)) begin
          new_row[w].rank = rd_row_r[w].rank + RANK_W'(1);
        end
        if (WAY_W'(w) == found) new_row[w].rank = '0;
      end else begin
        if (WAY_W'(w) == victim) begin
          new_row[w].valid = 1'b1;
          new_row[w].tag   = tag_r;
          new_row[w].rank  = '0;
        end else if (active[w] && rd_row_r[w].valid &&
                     (has_inv || (rd_row_r[w].rank < vic_rank))) begin
          new_row[w].rank = rd_row_r[w].rank + RANK_W'(1);
        end
      end
    end
  end

  // saturating counters
  function automatic logic [COUNTER_BITS-1:0] sat_inc(input logic [COUNTER_BITS-1:0] c);
    sat_inc = (&c) ? c : c + COUNTER_BITS'(1);
  endfunction

  function automatic logic [OUT_CNT_W-1:0] to_out(input logic [COUNTER_BITS-1:0] c);
    logic [63:0] wide;
    wide   = 64'(c);
    to_out = wide[OUT_CNT_W-1:0];
  endfunction

  logic [COUNTER_BITS-1:0] acc_r, rd_r, rdm_r, wr_r, wrm_r;
  logic [COUNTER_BITS-1:0] acc_nxt, rd_nxt, rdm_nxt, wr_nxt, wrm_nxt;

  always_comb begin
    acc_nxt = sat_inc(acc_r);
    rd_nxt  = rd_r;
    rdm_nxt = rdm_r;
    wr_nxt  = wr_r;
    wrm_nxt = wrm_r;
    if (op_r == OP_WRITE) begin
      wr_nxt = sat_inc(wr_r);
      if (!hit) wrm_nxt = sat_inc(wrm_r);
    end else begin
      rd_nxt = sat_inc(rd_r);
      if (!hit) rdm_nxt = sat_inc(rdm_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_hit) begin
      acc_r <= '0;
      rd_r  <= '0;
      rdm_r <= '0;
      wr_r  <= '0;
      wrm_r <= '0;
    end else if (cmd.update) begin
      acc_r <= acc_nxt;
      rd_r  <= rd_nxt;
      rdm_r <= rdm_nxt;
      wr_r  <= wr_nxt;
      wrm_r <= wrm_nxt;
    end
  end

  // result register, one-cycle strobe
  logic        out_valid_r;
  out_result_t out_result_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.update;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      out_result_r.hit              <= hit;
      out_result_r.access_count     <= to_out(acc_nxt);
      out_result_r.read_count       <= to_out(rd_nxt);
      out_result_r.read_miss_count  <= to_out(rdm_nxt);
      out_result_r.write_count      <= to_out(wr_nxt);
      out_result_r.write_miss_count <= to_out(wrm_nxt);
    end
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

endmodule : sacl_dpath
`default_nettype wire
